// ===== design/fsq25519_pkg.sv =====
// ----------------------------------------------------------------------------
// fsq25519_pkg
// Shared widths and word types for the radix 2^51 field squaring pipeline.
// ----------------------------------------------------------------------------
package fsq25519_pkg;

  localparam int unsigned LIMB_W   = 51;
  localparam int unsigned IN_W     = 54;
  localparam int unsigned OUT1_W   = LIMB_W + 1;
  localparam int unsigned OP_W     = 60;
  localparam int unsigned HALF_W   = OP_W / 2;
  localparam int unsigned PP_W     = 2 * HALF_W;
  localparam int unsigned PROD_W   = 2 * OP_W;
  localparam int unsigned COL_W    = 116;
  localparam int unsigned CARRY_W  = 64;
  localparam int unsigned CARRY_HI = LIMB_W + CARRY_W - 1;
  localparam int unsigned N_COL    = 5;
  localparam int unsigned N_TERM   = 3;
  localparam int unsigned N_PAIR   = N_COL * N_TERM;

  typedef struct packed {
    logic [IN_W-1:0] limb_in0;
    logic [IN_W-1:0] limb_in1;
    logic [IN_W-1:0] limb_in2;
    logic [IN_W-1:0] limb_in3;
    logic [IN_W-1:0] limb_in4;
  } in_word_t;

  typedef struct packed {
    logic [LIMB_W-1:0] limb_out0;
    logic [OUT1_W-1:0] limb_out1;
    logic [LIMB_W-1:0] limb_out2;
    logic [LIMB_W-1:0] limb_out3;
    logic [LIMB_W-1:0] limb_out4;
  } out_word_t;

  typedef logic [N_PAIR-1:0][OP_W-1:0]   op_vec_t;
  typedef logic [N_PAIR-1:0][PROD_W-1:0] prod_vec_t;
  typedef logic [N_COL-1:0][COL_W-1:0]   col_vec_t;

endpackage

// ===== design/fsq25519_prod.sv =====
// ----------------------------------------------------------------------------
// fsq25519_prod
// Fifteen 60x60 products, split into 30x30 partial products in the first
// stage and recombined in the second.
// ----------------------------------------------------------------------------
module fsq25519_prod (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  fsq25519_pkg::op_vec_t   op_a_i,
  input  fsq25519_pkg::op_vec_t   op_b_i,
  output logic                    valid_o,
  output fsq25519_pkg::prod_vec_t prod_o
);
  import fsq25519_pkg::*;

  logic      pp_valid_q;
  logic      prod_valid_q;
  prod_vec_t prod_q;

  for (genvar p = 0; p < N_PAIR; p++) begin : g_pair
    logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [PP_W-1:0]   pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
    logic [PROD_W-1:0] prod_d;

    assign a_lo = op_a_i[p][HALF_W-1:0];
    assign a_hi = op_a_i[p][OP_W-1:HALF_W];
    assign b_lo = op_b_i[p][HALF_W-1:0];
    assign b_hi = op_b_i[p][OP_W-1:HALF_W];

    always_ff @(posedge clk_i) begin
      if (valid_i) begin
        pp_ll_q <= PP_W'(a_lo) * PP_W'(b_lo);
        pp_lh_q <= PP_W'(a_lo) * PP_W'(b_hi);
        pp_hl_q <= PP_W'(a_hi) * PP_W'(b_lo);
        pp_hh_q <= PP_W'(a_hi) * PP_W'(b_hi);
      end
    end

    assign prod_d = PROD_W'(pp_ll_q)
                  + ((PROD_W'(pp_lh_q) + PROD_W'(pp_hl_q)) << HALF_W)
                  + (PROD_W'(pp_hh_q) << (2 * HALF_W));

    always_ff @(posedge clk_i) begin
      if (pp_valid_q) begin
        prod_q[p] <= prod_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      pp_valid_q   <= valid_i;
      prod_valid_q <= pp_valid_q;
    end
  end

  assign valid_o = prod_valid_q;
  assign prod_o  = prod_q;

endmodule

// ===== design/fsq25519_column.sv =====
// ----------------------------------------------------------------------------
// fsq25519_column
// Adds the three products of each column of the folded schoolbook square.
// ----------------------------------------------------------------------------
module fsq25519_column (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  fsq25519_pkg::prod_vec_t prod_i,
  output logic                    valid_o,
  output fsq25519_pkg::col_vec_t  col_o
);
  import fsq25519_pkg::*;

  logic     col_valid_q;
  col_vec_t col_q;
  col_vec_t col_d;

  always_comb begin
    for (int c = 0; c < N_COL; c++) begin
      col_d[c] = prod_i[N_TERM*c][COL_W-1:0]
               + prod_i[N_TERM*c+1][COL_W-1:0]
               + prod_i[N_TERM*c+2][COL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_valid_q <= 1'b0;
    end else begin
      col_valid_q <= valid_i;
    end
  end

  assign valid_o = col_valid_q;
  assign col_o   = col_q;

endmodule

// ===== design/fsq25519_carry.sv =====
// ----------------------------------------------------------------------------
// fsq25519_carry
// Carry chain over the five columns, one column per stage, then the fold of
// the top carry times 19 into limb 0 and the last carry into limb 1.
// ----------------------------------------------------------------------------
module fsq25519_carry (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  fsq25519_pkg::col_vec_t  col_i,
  output logic                    valid_o,
  output fsq25519_pkg::out_word_t word_o
);
  import fsq25519_pkg::*;

  localparam int unsigned N_STG = N_COL - 1;

  col_vec_t             cv_q [N_STG];
  logic     [N_STG-1:0] cv_valid_q;

  for (genvar s = 0; s < N_STG; s++) begin : g_stage
    col_vec_t col_in;
    col_vec_t col_d;
    logic     valid_in;

    if (s == 0) begin : g_first
      assign col_in   = col_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign col_in   = cv_q[s-1];
      assign valid_in = cv_valid_q[s-1];
    end

    always_comb begin
      col_d      = col_in;
      col_d[s+1] = col_in[s+1] + COL_W'(col_in[s][CARRY_HI:LIMB_W]);
    end

    always_ff @(posedge clk_i) begin
      if (valid_in) begin
        cv_q[s] <= col_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_valid_q[s] <= 1'b0;
      end else begin
        cv_valid_q[s] <= valid_in;
      end
    end
  end

  // fold of the top carry: 2^255 = 19 mod p
  col_vec_t             last;
  logic [CARRY_W-1:0]   top_carry;
  logic [CARRY_W-1:0]   fold;
  out_word_t            word_d;
  out_word_t            word_q;
  logic                 out_valid_q;

  assign last      = cv_q[N_STG-1];
  assign top_carry = last[N_COL-1][CARRY_HI:LIMB_W];
  assign fold      = CARRY_W'(last[0][LIMB_W-1:0])
                   + (top_carry << 4) + (top_carry << 1) + top_carry;

  always_comb begin
    word_d.limb_out0 = fold[LIMB_W-1:0];
    word_d.limb_out1 = OUT1_W'(last[1][LIMB_W-1:0])
                     + OUT1_W'(fold[CARRY_W-1:LIMB_W]);
    word_d.limb_out2 = last[2][LIMB_W-1:0];
    word_d.limb_out3 = last[3][LIMB_W-1:0];
    word_d.limb_out4 = last[4][LIMB_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cv_valid_q[N_STG-1]) begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cv_valid_q[N_STG-1];
    end
  end

  assign valid_o = out_valid_q;
  assign word_o  = word_q;

endmodule

// ===== design/field_square_p25519_radix51.sv =====
// ----------------------------------------------------------------------------
// field_square_p25519_radix51
// The result strobe follows the start through nine register stages: operand,
// two multiplier, column, four carry and fold.
// Throughput: one word per cycle; busy is never raised, the pipeline runs free.
// Reset clears only the valid bits; results are not held for the receiver.
// ----------------------------------------------------------------------------
module field_square_p25519_radix51 (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  fsq25519_pkg::in_word_t  word_i,
  output logic                    result_valid_o,
  output fsq25519_pkg::out_word_t word_o
);
  import fsq25519_pkg::*;

  function automatic logic [OP_W-1:0] times19(input logic [OP_W-1:0] x);
    times19 = (x << 4) + (x << 1) + x;
  endfunction

  logic            accept;
  logic [OP_W-1:0] x0, x1, x2, x3, x4;
  logic [OP_W-1:0] d0, d1;
  op_vec_t         op_a_d, op_b_d;
  op_vec_t         op_a_q, op_b_q;
  logic            op_valid_q;
  logic            prod_valid;
  prod_vec_t       prod;
  logic            col_valid;
  col_vec_t        col;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign x0 = OP_W'(word_i.limb_in0);
  assign x1 = OP_W'(word_i.limb_in1);
  assign x2 = OP_W'(word_i.limb_in2);
  assign x3 = OP_W'(word_i.limb_in3);
  assign x4 = OP_W'(word_i.limb_in4);
  assign d0 = x0 << 1;
  assign d1 = x1 << 1;

  always_comb begin
    // column 0
    op_a_d[0]  = x0;                op_b_d[0]  = x0;
    op_a_d[1]  = times19(x1) << 1;  op_b_d[1]  = x4;
    op_a_d[2]  = times19(x2);       op_b_d[2]  = x3 << 1;
    // column 1
    op_a_d[3]  = d0;                op_b_d[3]  = x1;
    op_a_d[4]  = times19(x2) << 1;  op_b_d[4]  = x4;
    op_a_d[5]  = times19(x3);       op_b_d[5]  = x3;
    // column 2
    op_a_d[6]  = d0;                op_b_d[6]  = x2;
    op_a_d[7]  = x1;                op_b_d[7]  = x1;
    op_a_d[8]  = times19(x3) << 1;  op_b_d[8]  = x4;
    // column 3
    op_a_d[9]  = d0;                op_b_d[9]  = x3;
    op_a_d[10] = d1;                op_b_d[10] = x2;
    op_a_d[11] = times19(x4);       op_b_d[11] = x4;
    // column 4
    op_a_d[12] = d0;                op_b_d[12] = x4;
    op_a_d[13] = d1;                op_b_d[13] = x3;
    op_a_d[14] = x2;                op_b_d[14] = x2;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_a_q <= op_a_d;
      op_b_q <= op_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else begin
      op_valid_q <= accept;
    end
  end

  fsq25519_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (op_valid_q),
    .op_a_i  (op_a_q),
    .op_b_i  (op_b_q),
    .valid_o (prod_valid),
    .prod_o  (prod)
  );

  fsq25519_column u_column (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .prod_i  (prod),
    .valid_o (col_valid),
    .col_o   (col)
  );

  fsq25519_carry u_carry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (col_valid),
    .col_i   (col),
    .valid_o (result_valid_o),
    .word_o  (word_o)
  );

endmodule
